/* rtl/dfs_pkg.sv */
package dfs_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);

  typedef struct packed {
    logic       func;
    logic [6:0] from_vertex;
    logic [6:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [6:0] vertex;
    logic       last;
    logic       edges_dropped;
  } out_item_t;

  typedef enum logic [0:0] {
    FUNC_ADD  = 1'b0,
    FUNC_SORT = 1'b1
  } func_t;

endpackage

/* rtl/dfs_ram.sv */
module dfs_ram #(
  parameter int Depth = 256,
  parameter int Width = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dfs_topological_sort.sv */
// DFS topological sort.
// Input channel (in, in_valid, in_stall): func=0 requests append one edge
// (1-based endpoints); loading never stalls, so edges load back to back.
// Out-of-range endpoints or a full store (256 entries) drop the edge and set a
// drop flag reported with the next sort.
// func=1 requests a sort: depth-first search from vertex 1 upward, following
// out-edges in arrival order. Each edge examined costs an edge memory read
// (S_READ) then a compare (S_SCAN), each frame scans the edge list at most
// once in total, and each pop adds an S_POP step to read the parent frame
// back from the stack memory. Then n results leave on out/out_valid/out_stall
// in reverse finish order, each passing through S_EMIT and S_WAIT; last
// marks the end.
// The input stalls during the search and the emit phase; a stalled result
// holds. After the sort the edge store, visited marks and flag are cleared.
// Reset (rst, synchronous) empties the store and sets vertex_count to 64.
// cfg_valid/cfg_ready write vertex_count; 0 acts as 1, above 64 as 64.
module dfs_topological_sort (
  input  logic               clk,
  input  logic               rst,
  input  dfs_pkg::in_item_t  in,
  input  logic               in_valid,
  output logic               in_stall,
  output dfs_pkg::out_item_t out,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic [6:0]         cfg,
  input  logic               cfg_valid,
  output logic               cfg_ready
);

  localparam int VW = dfs_pkg::VW;
  localparam int EW = dfs_pkg::EW;
  localparam int MaxV = dfs_pkg::MaxVertices;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b00000001,
    S_ROOT  = 8'b00000010,
    S_READ  = 8'b00000100,
    S_SCAN  = 8'b00001000,
    S_POP   = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_WAIT  = 8'b01000000,
    S_DRAIN = 8'b10000000
  } state_t;

  state_t state;
  logic [6:0] vertex_count;
  logic [EW:0] edge_count;
  logic dropped;
  logic [MaxV-1:0] visited;
  logic [VW:0] depth;
  logic [VW:0] root;
  logic [EW:0] epos;
  logic [EW:0] epos_inc;
  logic [VW-1:0] cur_v;
  logic [VW:0] fcount;

  // edge memory
  logic e_we;
  logic [EW-1:0] e_raddr;
  logic [2*VW-1:0] e_rdata;
  logic [VW-1:0] in_f, in_t;
  logic [VW:0] n_eff;

  dfs_ram #(.Depth(dfs_pkg::MaxEdges), .Width(2*VW)) u_edges (
    .clk(clk), .we(e_we), .waddr(edge_count[EW-1:0]), .wdata({in_f, in_t}),
    .raddr(e_raddr), .rdata(e_rdata));

  // finish order memory
  logic f_we;
  logic [VW-1:0] f_raddr;
  logic [VW-1:0] f_rdata;
  dfs_ram #(.Depth(MaxV), .Width(VW)) u_finish (
    .clk(clk), .we(f_we), .waddr(fcount[VW-1:0]), .wdata(cur_v),
    .raddr(f_raddr), .rdata(f_rdata));

  // parent frames: vertex and resume position
  logic [VW-1:0] top;
  logic s_we;
  logic [VW-1:0] s_raddr;
  logic [VW+EW:0] s_rdata;
  dfs_ram #(.Depth(MaxV), .Width(VW+EW+1)) u_stack (
    .clk(clk), .we(s_we), .waddr(top), .wdata({cur_v, epos_inc}),
    .raddr(s_raddr), .rdata(s_rdata));

  always_comb begin
    if (vertex_count == 7'd0) n_eff = (VW+1)'(1);
    else if (vertex_count > 7'(MaxV)) n_eff = (VW+1)'(MaxV);
    else n_eff = vertex_count[VW:0];
    in_f = VW'(in.from_vertex - 7'd1);
    in_t = VW'(in.to_vertex - 7'd1);
  end

  logic in_ok;
  assign in_ok = in.from_vertex != 7'd0 && in.from_vertex <= 7'(n_eff)
              && in.to_vertex != 7'd0 && in.to_vertex <= 7'(n_eff)
              && edge_count < (EW+1)'(dfs_pkg::MaxEdges);

  assign in_stall  = state != S_LOAD;
  assign cfg_ready = state == S_LOAD;
  wire in_take = in_valid && !in_stall;
  assign e_we = in_take && in.func == dfs_pkg::FUNC_ADD && in_ok;

  assign top = VW'(depth - 1'b1);
  assign e_raddr = epos[EW-1:0];
  assign epos_inc = epos + 1'b1;
  assign s_raddr = VW'(depth - 2'd2);

  wire [VW-1:0] es = e_rdata[2*VW-1:VW];
  wire [VW-1:0] et = e_rdata[VW-1:0];
  wire e_hit = es == cur_v && {1'b0, es} < n_eff && {1'b0, et} < n_eff;
  wire e_more = epos < edge_count;

  // save the current frame when descending into an unvisited target
  assign s_we = state == S_SCAN && e_more && e_hit && !visited[et];
  assign f_we = state == S_SCAN && !e_more;
  // emit pointer
  logic [VW:0] eidx;
  assign f_raddr = VW'(eidx - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      vertex_count <= 7'd64;
      edge_count <= '0;
      dropped <= 1'b0;
      visited <= '0;
      depth <= '0;
      fcount <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) vertex_count <= cfg;
      case (state)
        S_LOAD: if (in_take) begin
          if (in.func == dfs_pkg::FUNC_ADD) begin
            if (in_ok) edge_count <= edge_count + 1'b1;
            else dropped <= 1'b1;
          end else begin
            root <= '0;
            fcount <= '0;
            depth <= '0;
            visited <= '0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root == n_eff) begin
            eidx <= fcount;
            state <= S_EMIT;
          end else if (visited[root[VW-1:0]]) begin
            root <= root + 1'b1;
          end else begin
            visited[root[VW-1:0]] <= 1'b1;
            depth <= (VW+1)'(1);
            cur_v <= root[VW-1:0];
            epos <= '0;
            root <= root + 1'b1;
            state <= S_READ;
          end
        end
        S_READ: state <= S_SCAN;
        S_SCAN: begin
          if (e_more && e_hit && !visited[et]) begin
            visited[et] <= 1'b1;
            depth <= depth + 1'b1;
            cur_v <= et;
            epos <= '0;
            state <= S_READ;
          end else if (e_more) begin
            epos <= epos_inc;
            state <= S_READ;
          end else begin
            fcount <= fcount + 1'b1;
            depth <= depth - 1'b1;
            if (depth == (VW+1)'(1)) begin
              state <= S_ROOT;
            end else begin
              state <= S_POP;
            end
          end
        end
        // resume the parent frame read from the stack memory
        S_POP: begin
          cur_v <= s_rdata[VW+EW:EW+1];
          epos <= s_rdata[EW:0];
          state <= S_READ;
        end
        S_EMIT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b0;
          state <= S_WAIT;
        end
        S_WAIT: begin
          out.vertex <= 7'(f_rdata) + 7'd1;
          out.last <= eidx == (VW+1)'(1);
          out.edges_dropped <= dropped;
          out_valid <= 1'b1;
          eidx <= eidx - 1'b1;
          state <= (eidx == (VW+1)'(1)) ? S_DRAIN : S_EMIT;
        end
        S_DRAIN: if (!out_stall) begin
          out_valid <= 1'b0;
          edge_count <= '0;
          dropped <= 1'b0;
          visited <= '0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

/* sim/dfs_topological_sort_checker.sv */
module dfs_topological_sort_checker (
  input  logic               clk,
  input  logic               rst,
  input  dfs_pkg::in_item_t  in,
  input  logic               in_valid,
  input  logic               in_stall,
  input  dfs_pkg::out_item_t out,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [6:0]         cfg,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  output int                 fail_count,
  output int                 pending,
  output int                 sorts_seen,
  output int                 vertices_seen
);

  logic [5:0] src_mem [dfs_pkg::MaxEdges];
  logic [5:0] dst_mem [dfs_pkg::MaxEdges];
  int         n_edges;
  logic       dropped;
  logic [6:0] vcount;
  dfs_pkg::out_item_t order_q [$];

  function automatic int eff_n();
    if (vcount == 0) return 1;
    if (vcount > dfs_pkg::MaxVertices) return dfs_pkg::MaxVertices;
    return vcount;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Walk the graph and queue the vertices in reverse finish order.
  task automatic predict_topo_order();
    int n, depth, nfin, v, e, s, t;
    bit found;
    bit seen [dfs_pkg::MaxVertices];
    int stk_v [dfs_pkg::MaxVertices];
    int stk_e [dfs_pkg::MaxVertices];
    int fin [dfs_pkg::MaxVertices];
    dfs_pkg::out_item_t r;
    n = eff_n();
    depth = 0;
    nfin = 0;
    foreach (seen[i]) seen[i] = 0;
    for (int root = 0; root < n; root++) begin
      if (seen[root]) continue;
      seen[root] = 1; stk_v[0] = root; stk_e[0] = 0; depth = 1;
      while (depth > 0) begin
        v = stk_v[depth-1];
        e = stk_e[depth-1];
        found = 0;
        while (e < n_edges) begin
          s = src_mem[e]; t = dst_mem[e];
          e++;
          if (s == v && s < n && t < n) begin
            stk_e[depth-1] = e;
            if (!seen[t] && depth < dfs_pkg::MaxVertices) begin
              seen[t] = 1; stk_v[depth] = t; stk_e[depth] = 0; depth++;
            end
            found = 1;
            break;
          end
        end
        if (!found) begin
          depth--;
          fin[nfin++] = v;
        end
      end
    end
    for (int k = 0; k < nfin; k++) begin
      r.vertex = 7'(fin[nfin-1-k] + 1);
      r.last = (k + 1 == nfin);
      r.edges_dropped = dropped;
      order_q.insert(order_q.size(), r);
    end
    n_edges = 0;
    dropped = 0;
  endtask

  assign pending = order_q.size();

  always @(posedge clk) begin
    dfs_pkg::out_item_t x;
    if (rst) begin
      n_edges = 0;
      dropped = 0;
      vcount = 7'd64;
      fail_count = 0;
      sorts_seen = 0;
      vertices_seen = 0;
      order_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) vcount = cfg;
      if (out_valid && !out_stall) begin
        vertices_seen++;
        if (order_q.size() == 0) begin
          report("unexpected vertex", out.vertex, 0);
        end else begin
          x = order_q.pop_front();
          if (out.vertex != x.vertex) report("vertex", out.vertex, x.vertex);
          if (out.last != x.last) report("last", out.last, x.last);
          if (out.edges_dropped != x.edges_dropped)
            report("edges_dropped", out.edges_dropped, x.edges_dropped);
        end
      end
      if (in_valid && !in_stall) begin
        if (in.func == dfs_pkg::FUNC_SORT) begin
          sorts_seen++;
          predict_topo_order();
        end else if (in.from_vertex == 0 || in.from_vertex > eff_n() ||
                     in.to_vertex == 0 || in.to_vertex > eff_n() ||
                     n_edges >= dfs_pkg::MaxEdges) begin
          dropped = 1;
        end else begin
          src_mem[n_edges] = 6'(in.from_vertex - 1);
          dst_mem[n_edges] = 6'(in.to_vertex - 1);
          n_edges++;
        end
      end
    end
  end
endmodule

/* sim/dfs_topological_sort_test.sv */
module dfs_topological_sort_test;

  logic      clk = 0;
  logic      rst = 1;
  dfs_pkg::in_item_t  in = '0;
  logic      in_valid = 0;
  logic      in_stall;
  dfs_pkg::out_item_t out;
  logic      out_valid;
  logic      out_stall = 0;
  logic [6:0] cfg = 7'd64;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  int        fail_count, pending, sorts_seen, vertices_seen;
  bit        hold_off = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  dfs_topological_sort dut (
    .clk, .rst, .in, .in_valid, .in_stall, .out, .out_valid, .out_stall,
    .cfg, .cfg_valid, .cfg_ready
  );

  dfs_topological_sort_checker chk (
    .clk, .rst, .in, .in_valid, .in_stall, .out, .out_valid, .out_stall,
    .cfg, .cfg_valid, .cfg_ready, .fail_count, .pending, .sorts_seen,
    .vertices_seen
  );

  // Receiver: random stall per result, with a long hold-off on request.
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  // Valid stays high after acceptance so requests can follow back to back.
  task automatic send(input dfs_pkg::func_t func, input logic [6:0] f,
                      input logic [6:0] t, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 10) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in.func <= func;
    in.from_vertex <= f;
    in.to_vertex <= t;
    in_valid <= 1;
    @(posedge clk iff !in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk iff pending == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_count(input logic [6:0] v);
    cfg <= v;
    cfg_valid <= 1;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic sort_graph(input int n, input int edges, input bit gaps);
    int f, t;
    for (int i = 0; i < edges; i++) begin
      f = $urandom_range(1, n);
      t = $urandom_range(1, n);
      // mostly forward edges so most graphs are acyclic; a few bad endpoints
      if ($urandom_range(0, 3) != 0 && f > t) begin
        int x; x = f; f = t; t = x;
      end
      if ($urandom_range(0, 19) == 0) f = $urandom_range(0, 127);
      if ($urandom_range(0, 19) == 0) t = $urandom_range(0, 127);
      send(dfs_pkg::FUNC_ADD, 7'(f), 7'(t), gaps);
    end
    send(dfs_pkg::FUNC_SORT, 7'($urandom), 7'($urandom), gaps);
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: reset count 64, extreme endpoints and out-of-range drops.
    send(dfs_pkg::FUNC_ADD, 7'd1, 7'd64, 0);
    send(dfs_pkg::FUNC_ADD, 7'd64, 7'd2, 0);
    send(dfs_pkg::FUNC_ADD, 7'd2, 7'd1, 0);
    send(dfs_pkg::FUNC_ADD, 7'd0, 7'd5, 0);
    send(dfs_pkg::FUNC_ADD, 7'd127, 7'd65, 0);
    send(dfs_pkg::FUNC_SORT, 7'h7f, 7'h55, 0);
    drain();
    write_count(7'd0);
    send(dfs_pkg::FUNC_ADD, 7'd1, 7'd1, 0);
    send(dfs_pkg::FUNC_ADD, 7'd1, 7'd2, 0);
    send(dfs_pkg::FUNC_SORT, 7'd0, 7'd0, 0);
    drain();
    // Lowered count after loading: stored edges past the new count are skipped.
    write_count(7'd5);
    send(dfs_pkg::FUNC_ADD, 7'd1, 7'd5, 0);
    send(dfs_pkg::FUNC_ADD, 7'd5, 7'd3, 0);
    send(dfs_pkg::FUNC_ADD, 7'd3, 7'd1, 0);
    send(dfs_pkg::FUNC_ADD, 7'd2, 7'd4, 0);
    drain();
    write_count(7'd3);
    send(dfs_pkg::FUNC_SORT, 7'd0, 7'd0, 0);
    drain();
    write_count(7'd127);
    // Full store: 258 additions overflow the 256 slots.
    for (int i = 0; i < 258; i++)
      send(dfs_pkg::FUNC_ADD, 7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)), 0);
    hold_off = 1;
    send(dfs_pkg::FUNC_SORT, 7'd0, 7'd0, 0);
    send(dfs_pkg::FUNC_ADD, 7'd1, 7'd2, 0);
    send(dfs_pkg::FUNC_SORT, 7'd0, 7'd0, 0);
    drain();
    // Random phases over several vertex counts.
    for (int p = 0; p < 4; p++) begin
      n = (p == 0) ? 1 : (p == 1) ? 64 : (p == 2) ? 2 : $urandom_range(3, 20);
      write_count(7'(n));
      for (int g = 0; g < 2; g++)
        sort_graph(n, $urandom_range(0, 6), (g % 2) == 1);
      drain();
    end
    write_count(7'd64);
    sort_graph(64, 12, 1);
    drain();
    $display("covered %0d sorts and %0d emitted vertices", sorts_seen, vertices_seen);
    $display("vertex counts from 0 to 127, drops, overflow and a long output hold-off");
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
